>>> sv/eoc_pkg.sv
// Shared constants of the elevation obstacle classifier: field widths, register indexes, classes.
package eoc_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 10;
  localparam int POS_W      = 9;
  localparam int CLASS_W    = 2;
  localparam int GAP_W      = 16;
  localparam int THR_W      = 16;
  localparam int MIN_DIM    = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CLASS_W-1:0]   cell_class_t;

  localparam cfg_idx_t REG_COLS_IN_ROW      = 2'd0;
  localparam cfg_idx_t REG_ROWS_IN_FRAME    = 2'd1;
  localparam cfg_idx_t REG_OBJECT_THRESHOLD = 2'd2;

  localparam cell_class_t CLASS_UNKNOWN  = 2'd0;
  localparam cell_class_t CLASS_ROAD     = 2'd1;
  localparam cell_class_t CLASS_OBSTACLE = 2'd2;

  localparam logic [DIM_W-1:0] COLS_RESET      = 10'd512;
  localparam logic [DIM_W-1:0] ROWS_RESET      = 10'd512;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd70;

endpackage

>>> sv/eoc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module eoc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/elevation_obstacle_classifier_unit.sv
// Top level of the elevation obstacle classifier: line stores, 3x3 window and step classifier.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | height, detected, frame_start
//   out_    | output    | out_valid / out_ready | center_row, center_col, cell_class, max_gap
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// One cell per cycle while in_ready is high; results, if any, leave via the output register.
// The line stores are read in the input cycle and written back in the classify cycle.
// After reset the line stores are cleared over all MAX_COLS addresses with in_ready low.
// A stalled output beat holds the classify stage, which in turn holds in_ready low.
module elevation_obstacle_classifier_unit #(
  parameter int MAX_COLS    = 512,
  parameter int MAX_ROWS    = 512,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [HEIGHT_BITS-1:0]        in_height,
  input  logic                                 in_detected,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [eoc_pkg::POS_W-1:0]            out_center_row,
  output logic [eoc_pkg::POS_W-1:0]            out_center_col,
  output logic [eoc_pkg::CLASS_W-1:0]          out_cell_class,
  output logic [eoc_pkg::GAP_W-1:0]            out_max_gap,
  input  logic                                 cfg_we,
  input  logic [eoc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eoc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import eoc_pkg::*;

  localparam int HB     = HEIGHT_BITS;
  localparam int CELL_W = HB + 1;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COLS_W = COL_W + 1;
  localparam int ROWS_W = ROW_W + 1;
  localparam int CEW    = (COLS_W > DIM_W) ? COLS_W : DIM_W;
  localparam int REW    = (ROWS_W > DIM_W) ? ROWS_W : DIM_W;
  localparam int CMP_W  = (HB > THR_W) ? HB : THR_W;

  // Configuration registers.
  logic [DIM_W-1:0] cols_cfg_r;
  logic [DIM_W-1:0] rows_cfg_r;
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLS_RESET;
      rows_cfg_r <= ROWS_RESET;
      thr_r      <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS_IN_ROW:      cols_cfg_r <= cfg_data[DIM_W-1:0];
        REG_ROWS_IN_FRAME:    rows_cfg_r <= cfg_data[DIM_W-1:0];
        REG_OBJECT_THRESHOLD: thr_r      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;

  always_comb begin
    if (CEW'(cols_cfg_r) < CEW'(MIN_DIM)) begin
      cols_eff = COLS_W'(MIN_DIM);
    end else if (CEW'(cols_cfg_r) > CEW'(MAX_COLS)) begin
      cols_eff = COLS_W'(MAX_COLS);
    end else begin
      cols_eff = COLS_W'(cols_cfg_r);
    end
    if (REW'(rows_cfg_r) < REW'(MIN_DIM)) begin
      rows_eff = ROWS_W'(MIN_DIM);
    end else if (REW'(rows_cfg_r) > REW'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = ROWS_W'(rows_cfg_r);
    end
  end

  // Line store clearing after reset.
  logic             clear_r;
  logic [COL_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == COL_W'(MAX_COLS - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // Handshake and stage control.
  logic s1_valid_r;
  logic s1_go;
  logic in_accept;
  logic out_valid_r;

  assign s1_go     = !out_valid_r || out_ready;
  assign in_ready  = !clear_r && (!s1_valid_r || s1_go);
  assign in_accept = in_valid && in_ready;

  // Position counters.
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;
  logic             last_col;
  logic             last_row;
  logic             has_res;
  logic             edge_cell;

  always_comb begin
    r0       = in_frame_start ? '0 : row_cnt_r;
    c0       = in_frame_start ? '0 : col_cnt_r;
    last_col = (COLS_W'(c0) + 1'b1) >= cols_eff;
    last_row = (ROWS_W'(r0) + 1'b1) >= rows_eff;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : ROW_W'(ROWS_W'(r0) + 1'b1);
    end else begin
      col_nxt = COL_W'(COLS_W'(c0) + 1'b1);
      row_nxt = r0;
    end
    has_res   = (r0 != '0) && (c0 != '0);
    edge_cell = (ROWS_W'(r0) < ROWS_W'(3)) || last_row ||
                (COLS_W'(c0) < COLS_W'(3)) || last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_accept) begin
      row_cnt_r <= row_nxt;
      col_cnt_r <= col_nxt;
    end
  end

  // Classify stage registers.
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_crow_r;
  logic [COL_W-1:0] s1_ccol_r;
  logic             s1_has_res_r;
  logic             s1_edge_r;
  logic [HB-1:0]    s1_h_r;
  logic             s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r     <= c0;
      s1_crow_r    <= r0 - 1'b1;
      s1_ccol_r    <= c0 - 1'b1;
      s1_has_res_r <= has_res;
      s1_edge_r    <= edge_cell;
      s1_h_r       <= in_height;
      s1_d_r       <= in_detected;
    end
  end

  // Line stores with a bypass for a back-to-back access to the same column.
  logic              s1_wr;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [CELL_W-1:0] up_wdata;
  logic [CELL_W-1:0] mid_wdata;
  logic [CELL_W-1:0] up_rdata;
  logic [CELL_W-1:0] mid_rdata;
  logic [CELL_W-1:0] up_eff;
  logic [CELL_W-1:0] mid_eff;
  logic [CELL_W-1:0] nc_cell;
  logic              fwd_r;
  logic [CELL_W-1:0] fwd_up_r;
  logic [CELL_W-1:0] fwd_mid_r;

  assign nc_cell   = {s1_d_r, s1_h_r};
  assign up_eff    = fwd_r ? fwd_up_r : up_rdata;
  assign mid_eff   = fwd_r ? fwd_mid_r : mid_rdata;
  assign s1_wr     = s1_valid_r && s1_go;
  assign ram_we    = clear_r || s1_wr;
  assign ram_waddr = clear_r ? clr_addr_r : s1_col_r;
  assign up_wdata  = clear_r ? '0 : mid_eff;
  assign mid_wdata = clear_r ? '0 : nc_cell;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_accept) begin
      fwd_r <= s1_wr && (c0 == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= nc_cell;
    end
  end

  eoc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAX_COLS)
  ) u_upper_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(up_wdata),
    .re   (in_accept),
    .raddr(c0),
    .rdata(up_rdata)
  );

  eoc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAX_COLS)
  ) u_middle_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(mid_wdata),
    .re   (in_accept),
    .raddr(c0),
    .rdata(mid_rdata)
  );

  // 3x3 window, indexed [row][column], column 2 newest.
  logic [HB-1:0] win_h_r [3][3];
  logic          win_d_r [3][3];
  logic [HB-1:0] new_h   [3][3];
  logic          new_d   [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      new_h[k][0] = win_h_r[k][1];
      new_d[k][0] = win_d_r[k][1];
      new_h[k][1] = win_h_r[k][2];
      new_d[k][1] = win_d_r[k][2];
    end
    new_h[0][2] = up_eff[HB-1:0];
    new_d[0][2] = up_eff[HB];
    new_h[1][2] = mid_eff[HB-1:0];
    new_d[1][2] = mid_eff[HB];
    new_h[2][2] = s1_h_r;
    new_d[2][2] = s1_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_d_r[i][j] <= 1'b0;
        end
      end
    end else if (s1_wr) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_d_r[i][j] <= new_d[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_h_r[i][j] <= new_h[i][j];
        end
      end
    end
  end

  // Step above each detected neighbor, then a three-level maximum tree.
  logic [HB:0]      diff  [8];
  logic [HB-1:0]    step  [8];
  logic [HB-1:0]    lvl1  [4];
  logic [HB-1:0]    lvl2  [2];
  logic [HB-1:0]    gap;
  logic [CMP_W-1:0] gap_ext;
  logic             ctr_d;
  logic [HB-1:0]    ctr_h;
  cell_class_t      cls;
  logic [GAP_W-1:0] gap_out;

  always_comb begin
    ctr_h = new_h[1][1];
    ctr_d = new_d[1][1];
    for (int n = 0; n < 8; n++) begin
      diff[n] = '0;
      step[n] = '0;
    end
    for (int n = 0; n < 8; n++) begin
      diff[n] = {ctr_h[HB-1], ctr_h} -
                {new_h[(n + n / 4) / 3][(n + n / 4) % 3][HB-1],
                 new_h[(n + n / 4) / 3][(n + n / 4) % 3]};
      if (new_d[(n + n / 4) / 3][(n + n / 4) % 3] && !diff[n][HB]) begin
        step[n] = diff[n][HB-1:0];
      end
    end
    for (int n = 0; n < 4; n++) begin
      lvl1[n] = (step[2*n] > step[2*n+1]) ? step[2*n] : step[2*n+1];
    end
    for (int n = 0; n < 2; n++) begin
      lvl2[n] = (lvl1[2*n] > lvl1[2*n+1]) ? lvl1[2*n] : lvl1[2*n+1];
    end
    gap     = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    gap_ext = CMP_W'(gap);
    if (s1_edge_r || !ctr_d) begin
      cls     = CLASS_UNKNOWN;
      gap_out = '0;
    end else begin
      cls     = (gap_ext > CMP_W'(thr_r)) ? CLASS_OBSTACLE : CLASS_ROAD;
      gap_out = (gap_ext > CMP_W'({GAP_W{1'b1}})) ? {GAP_W{1'b1}} : GAP_W'(gap_ext);
    end
  end

  // Output register.
  logic [POS_W-1:0]   out_row_r;
  logic [POS_W-1:0]   out_col_r;
  cell_class_t        out_class_r;
  logic [GAP_W-1:0]   out_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_wr && s1_has_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr && s1_has_res_r) begin
      out_row_r   <= POS_W'(s1_crow_r);
      out_col_r   <= POS_W'(s1_ccol_r);
      out_class_r <= cls;
      out_gap_r   <= gap_out;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center_row = out_row_r;
  assign out_center_col = out_col_r;
  assign out_cell_class = out_class_r;
  assign out_max_gap    = out_gap_r;

endmodule
